>>> rtl/core/vlmrq_pkg.sv
// Package for the variable-length message ring queue.
// Beat types, command type, back state, status codes and request codes; no dependencies.
`default_nettype none
package vlmrq_pkg;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BYTE     = 3'd3;
  localparam logic [2:0] ST_ZERO_LEN = 3'd4;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic       first;
    logic [6:0] msg_length;
    logic [7:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic [6:0] out_length;
    logic       last;
  } out_beat_t;

  // Command from front to back: either a single-beat reply or a pop stream
  typedef struct packed {
    logic        stream;   // 1: stream bytes from the store
    logic [2:0]  status;   // reply status when stream is 0
    logic [16:0] base;     // first data byte address
    logic [6:0]  len;
  } cmd_t;

  typedef enum logic [0:0] {BK_IDLE, BK_STREAM} bk_state_e;

endpackage
`default_nettype wire

>>> rtl/core/vlmrq_front.sv
// Front part: accepts request beats, runs ring and descriptor bookkeeping,
// writes pushed bytes, and issues reply/stream commands. Uses vlmrq_pkg.
`default_nettype none
module vlmrq_front #(
  parameter int BUF_BYTES    = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_LEN      = 64,
  parameter int MAX_MSGS     = 256
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push,
  output logic                    full,
  input  vlmrq_pkg::in_beat_t     in_i,
  // command queue side
  output logic                    cmd_valid_o,
  output vlmrq_pkg::cmd_t         cmd_o,
  input  wire                     cmd_full_i,
  // store write port
  output logic                    wr_en_o,
  output logic [$clog2(BUF_BYTES)-1:0] wr_addr_o,
  output logic [7:0]              wr_data_o
);
  localparam int AW = $clog2(BUF_BYTES) + 1;
  localparam int DW = $clog2(MAX_MSGS);
  localparam int CW = $clog2(MAX_MSGS + 1);
  localparam int BW = $clog2(BUF_BYTES);
  localparam logic [AW-1:0] BUF_A = AW'(BUF_BYTES);
  localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, pptr_q, pptr_d;
  logic [AW-1:0] ppos_q, ppos_d;   // position of the message being filled
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rdi_q, rdi_d, wri_q, wri_d;
  logic [6:0]    prem_q, prem_d;
  logic          pacc_q, pacc_d;

  // accepted beat, processed in the cycle after acceptance
  logic                busy_q;
  vlmrq_pkg::in_beat_t beat_q;

  // descriptor arrays and their registered read data
  logic [AW-1:0] dpos_mem [MAX_MSGS];
  logic [6:0]    dlen_mem [MAX_MSGS];
  logic [AW-1:0] rpos_q, npos_q;
  logic [6:0]    rlen_q;

  logic acc;
  logic pending;
  logic [DW-1:0] rdn;

  function automatic logic [DW-1:0] nxt(input logic [DW-1:0] i);
    nxt = ({1'b0, i} + 1'b1 >= (DW+1)'(MAX_MSGS)) ? '0 : i + 1'b1;
  endfunction

  logic          dw_en;
  logic [AW-1:0] dw_pos;
  logic [6:0]    len_c;
  logic [AW-1:0] wh, rt, need, space, pos;
  logic          rej;

  // one beat in flight: hold the input while it is processed
  assign full = busy_q || cmd_full_i;
  assign acc  = push && !full;

  assign pending = pacc_q && (prem_q != 7'd0);
  assign rdn = nxt(rdi_q);

  always_comb begin
    head_d = head_q; tail_d = tail_q; pptr_d = pptr_q; cnt_d = cnt_q;
    rdi_d = rdi_q; wri_d = wri_q; prem_d = prem_q; pacc_d = pacc_q;
    ppos_d = ppos_q;
    cmd_valid_o = 1'b0;
    cmd_o = '0;
    wr_en_o = 1'b0; wr_addr_o = '0; wr_data_o = beat_q.data_in;
    dw_en = 1'b0; dw_pos = '0;
    wh = head_q; rt = tail_q; need = '0; space = '0; pos = '0; rej = 1'b0;
    len_c = (rlen_q > 7'(MAX_LEN)) ? 7'(MAX_LEN) : rlen_q;
    if (busy_q) begin
      if (beat_q.req_type == vlmrq_pkg::REQ_POP) begin
        cmd_valid_o = 1'b1;
        if (cnt_q == '0) begin
          cmd_o.status = vlmrq_pkg::ST_EMPTY;
        end else begin
          if (len_c == 7'd0) begin
            cmd_o.status = vlmrq_pkg::ST_ZERO_LEN;
          end else begin
            cmd_o.stream = 1'b1;
            cmd_o.len = len_c;
            cmd_o.base = 17'(rpos_q + HDR_A);
          end
          rdi_d = rdn;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q > CW'(1) || pending) tail_d = npos_q;
          else tail_d = head_q;
        end
      end else if (beat_q.first) begin
        cmd_valid_o = 1'b1;
        if (pending) wh = ppos_q;
        prem_d = '0; pacc_d = 1'b0;
        need = HDR_A + AW'(beat_q.msg_length);
        if (beat_q.msg_length > 7'(MAX_LEN) || cnt_q >= CW'(MAX_MSGS)) rej = 1'b1;
        if (cnt_q != '0 && wh == rt) space = '0;
        else if (wh >= rt) space = (BUF_A > wh) ? BUF_A - wh : '0;
        else space = rt - wh;
        if (!rej && space < need) begin
          if (cnt_q == '0) begin
            wh = '0; rt = '0; space = BUF_A;
          end else if (wh > rt && rt > need) begin
            wh = '0; space = rt;
          end
        end
        if (space < need) rej = 1'b1;
        if (rej) begin
          cmd_o.status = vlmrq_pkg::ST_NO_SPACE;
          head_d = wh;
        end else begin
          cmd_o.status = vlmrq_pkg::ST_ACCEPTED;
          pos = wh;
          dw_en = 1'b1; dw_pos = pos;
          ppos_d = pos;
          head_d = pos + need;
          tail_d = rt;
          pacc_d = 1'b1;
          if (beat_q.msg_length == 7'd0) begin
            wri_d = nxt(wri_q); cnt_d = cnt_q + 1'b1;
          end else begin
            wr_en_o = (pos + HDR_A) < BUF_A;
            wr_addr_o = BW'(pos + HDR_A);
            pptr_d = pos + HDR_A + 1'b1;
            prem_d = beat_q.msg_length - 1'b1;
            if (beat_q.msg_length == 7'd1) begin
              wri_d = nxt(wri_q); cnt_d = cnt_q + 1'b1;
            end
          end
        end
        if (rej) tail_d = rt;
      end else if (pending) begin
        wr_en_o = pptr_q < BUF_A;
        wr_addr_o = BW'(pptr_q);
        pptr_d = pptr_q + 1'b1;
        prem_d = prem_q - 1'b1;
        if (prem_q == 7'd1) begin
          wri_d = nxt(wri_q); cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  // descriptor write, and registered reads of the oldest and next descriptors
  always_ff @(posedge clk_i) begin
    if (dw_en) begin
      dpos_mem[wri_q] <= dw_pos;
      dlen_mem[wri_q] <= beat_q.msg_length;
    end
    if (acc) begin
      rpos_q <= dpos_mem[rdi_q];
      npos_q <= dpos_mem[rdn];
      rlen_q <= dlen_mem[rdi_q];
    end
  end

  // beat holding register
  always_ff @(posedge clk_i) begin
    if (acc) beat_q <= in_i;
  end

  // bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; pptr_q <= '0; cnt_q <= '0;
      rdi_q <= '0; wri_q <= '0; prem_q <= '0; pacc_q <= 1'b0;
      ppos_q <= '0; busy_q <= 1'b0;
    end else begin
      head_q <= head_d; tail_q <= tail_d; pptr_q <= pptr_d; cnt_q <= cnt_d;
      rdi_q <= rdi_d; wri_q <= wri_d; prem_q <= prem_d; pacc_q <= pacc_d;
      ppos_q <= ppos_d; busy_q <= acc;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_MSGS)) else $error("message count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> $stable(cnt_q)) else $error("count moved without a beat");
  a_no_wr_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && beat_q.req_type == vlmrq_pkg::REQ_POP) |-> !wr_en_o)
    else $error("store write on pop");
endmodule
`default_nettype wire

>>> rtl/core/vlmrq_back.sv
// Back part: short command queue, byte store, and the result streamer
// with an output register. Uses vlmrq_pkg.
`default_nettype none
module vlmrq_back #(
  parameter int BUF_BYTES = 4096
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cmd_valid_i,
  input  vlmrq_pkg::cmd_t         cmd_i,
  output logic                    cmd_full_o,
  input  wire                     wr_en_i,
  input  wire [$clog2(BUF_BYTES)-1:0] wr_addr_i,
  input  wire [7:0]               wr_data_i,
  output logic                    empty,
  input  wire                     pop,
  output vlmrq_pkg::out_beat_t    out_o
);
  localparam int BW = $clog2(BUF_BYTES);

  logic [7:0] store_mem [BUF_BYTES];
  logic [7:0] rd_data_q;
  logic [BW-1:0] rd_addr;
  logic          rd_en;

  vlmrq_pkg::cmd_t cq_mem [2];
  logic       cq_wp_q, cq_rp_q;
  logic [1:0] cq_n_q;
  logic       cq_pop;
  logic       strm_busy;

  vlmrq_pkg::bk_state_e st_q, st_d;
  logic [16:0] addr_q, addr_d;
  logic [6:0]  idx_q, idx_d, len_q, len_d;
  logic        rd_pend_q, rd_pend_d, rd_last_q, rd_last_d;
  logic        ov_q, ov_d;         // out_o holds a beat
  vlmrq_pkg::out_beat_t ob_q, ob_d;
  logic        can_load;
  vlmrq_pkg::cmd_t hd;
  logic        p_last;

  // byte store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) store_mem[wr_addr_i] <= wr_data_i;
    if (rd_en) rd_data_q <= store_mem[rd_addr];
  end

  // two-entry command queue; full while any command is queued, a stream runs
  // or a store read is pending, which keeps store reads behind writes
  assign strm_busy = (cq_n_q != 2'd0) || (st_q != vlmrq_pkg::BK_IDLE) || rd_pend_q;
  assign cmd_full_o = (cq_n_q == 2'd2) || strm_busy;

  assign hd = cq_mem[cq_rp_q];
  assign empty = !ov_q;
  assign out_o = ob_q;
  // output register frees when empty or popped this cycle
  assign can_load = !ov_q || pop;

  always_comb begin
    st_d = st_q; addr_d = addr_q; idx_d = idx_q; len_d = len_q;
    rd_pend_d = 1'b0; rd_last_d = 1'b0; ov_d = ov_q && !pop; ob_d = ob_q;
    rd_en = 1'b0; rd_addr = BW'(addr_q); cq_pop = 1'b0; p_last = 1'b0;
    // deliver a store read into the output register
    if (rd_pend_q) begin
      ov_d = 1'b1;
      ob_d.status = vlmrq_pkg::ST_BYTE;
      ob_d.out_byte = rd_data_q;
      ob_d.out_length = len_q;
      ob_d.last = rd_last_q;
    end
    case (st_q)
      vlmrq_pkg::BK_IDLE: begin
        if (cq_n_q != 2'd0 && can_load && !rd_pend_q) begin
          cq_pop = 1'b1;
          if (hd.stream) begin
            st_d = vlmrq_pkg::BK_STREAM;
            addr_d = hd.base; idx_d = '0; len_d = hd.len;
          end else begin
            ov_d = 1'b1;
            ob_d = '0;
            ob_d.status = hd.status;
            ob_d.last = 1'b1;
          end
        end
      end
      vlmrq_pkg::BK_STREAM: begin
        // issue a read only with none in flight and the output slot freed now,
        // so the slot is empty when the read data lands
        if (can_load && !rd_pend_q) begin
          rd_en = 1'b1;
          rd_pend_d = 1'b1;
          p_last = (idx_q + 1'b1 == len_q);
          rd_last_d = p_last;
          addr_d = addr_q + 1'b1;
          idx_d = idx_q + 1'b1;
          if (p_last) st_d = vlmrq_pkg::BK_IDLE;
        end
      end
      default: st_d = vlmrq_pkg::BK_IDLE;
    endcase
  end

  // command queue
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) cq_mem[cq_wp_q] <= cmd_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_wp_q <= 1'b0; cq_rp_q <= 1'b0; cq_n_q <= '0;
    end else begin
      if (cmd_valid_i) cq_wp_q <= !cq_wp_q;
      if (cq_pop) cq_rp_q <= !cq_rp_q;
      cq_n_q <= cq_n_q + 2'(cmd_valid_i) - 2'(cq_pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= vlmrq_pkg::BK_IDLE; ov_q <= 1'b0; rd_pend_q <= 1'b0; rd_last_q <= 1'b0;
      idx_q <= '0; len_q <= '0; addr_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; rd_pend_q <= rd_pend_d; rd_last_q <= rd_last_d;
      idx_q <= idx_d; len_q <= len_d; addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !pop) |=> $stable(ob_q)) else $error("result overwritten");
  a_cq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_n_q <= 2'd2) else $error("command queue overflow");
  a_rd_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (!ov_q || pop)) else $error("read lands on full slot");
endmodule
`default_nettype wire

>>> rtl/core/variable_length_message_ring_queue_top.sv
// Top level: front bookkeeping part and back streaming part joined by
// a command queue. Uses vlmrq_pkg, vlmrq_front, vlmrq_back.
// Input: a beat is latched, then processed while full is high; a first-byte
// reply passes the beat, queue and output registers. Pop: bytes also pass the
// stream state and store read registers, one read at a time; new beats wait
// while a stream is queued or running. Reset: async low clears control state.
`default_nettype none
module variable_length_message_ring_queue_top #(
  parameter int BUF_BYTES    = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_LEN      = 64,
  parameter int MAX_MSGS     = 256
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push,
  output logic                  full,
  input  vlmrq_pkg::in_beat_t   in_i,
  output logic                  empty,
  input  wire                   pop,
  output vlmrq_pkg::out_beat_t  out_o
);
  logic                    cmd_valid, cmd_full, wr_en;
  vlmrq_pkg::cmd_t         cmd;
  logic [$clog2(BUF_BYTES)-1:0] wr_addr;
  logic [7:0]              wr_data;

  vlmrq_front #(.BUF_BYTES(BUF_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .MAX_LEN(MAX_LEN), .MAX_MSGS(MAX_MSGS)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_full_i(cmd_full),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data));

  vlmrq_back #(.BUF_BYTES(BUF_BYTES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_full_o(cmd_full),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .empty, .pop, .out_o);
endmodule
`default_nettype wire
